// ===== rtl/fmd_pkg.sv =====
package fmd_pkg;

   typedef enum logic [1:0] {
      OP_DX   = 2'd0,
      OP_DY   = 2'd1,
      OP_SYNC = 2'd2,
      OP_IDLE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_MOTION_THRESHOLD = 2'd0,
      REG_WINDOW_LENGTH    = 2'd1,
      REG_COOLDOWN         = 2'd2
   } reg_index_type;

   localparam int          THRESHOLD_WIDTH   = 24;
   localparam int          MS_CFG_WIDTH      = 16;
   localparam int          TIME_WIDTH        = 32;
   localparam int          DELTA_WIDTH       = 16;
   localparam int          CSR_DATA_WIDTH    = 24;
   localparam int          CSR_INDEX_WIDTH   = 2;
   localparam int          REQ_TDATA_WIDTH   = 48;
   localparam int          RSP_TDATA_WIDTH   = 8;

   localparam logic [23:0] THRESHOLD_RESET   = 24'd250;
   localparam logic [15:0] WINDOW_RESET      = 16'd40;
   localparam logic [15:0] COOLDOWN_RESET    = 16'd800;

endpackage

// ===== rtl/fast_motion_detector.sv =====
// fast_motion_detector
//
// Watches relative pointer events and raises a fast-motion flag.
// Input channel req_*: one event per item; req_tuser carries the opcode
// (x delta, y delta, frame sync, idle check), req_tdata the delta and a
// millisecond timestamp. Result channel rsp_*: exactly one item per input
// item, carrying the flag and its on/off edges.
// Configuration channel csr_*: threshold, window length and cooldown, written by
// index; always ready. Users write only while no event is in flight (not enforced).
//
// An accepted item is held in the input register, and then moves through the
// update logic into the result register once that register is free or being read.
// Throughput is one item per cycle while the receiver does not stall; the state
// update is a single add/compare pass between those two registers.
// When the receiver stalls, the result register holds, the input register
// fills, and req_tready drops; nothing is lost.
// Reset clears all sums, times and the flag, restores the default
// configuration (250, 40 ms, 800 ms) and empties both registers.
module fast_motion_detector
   import fmd_pkg::*;
#(
   parameter int ACC_WIDTH = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0]  req_tdata,   // delta[15:0], now_ms[47:16]
   input  logic [1:0]                  req_tuser,   // opcode[1:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0]  rsp_tdata,   // fast_active, became_active,
                                                    // became_inactive, zero pad
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int CMP_WIDTH = TIME_WIDTH + 1;

   // configuration
   logic [THRESHOLD_WIDTH-1:0] threshold_ff, threshold_in;
   logic [MS_CFG_WIDTH-1:0]    window_len_ff, window_len_in;
   logic [MS_CFG_WIDTH-1:0]    cooldown_ff, cooldown_in;

   // input register
   logic                       s1_valid_ff, s1_valid_in;
   op_type                     s1_op_ff, s1_op_in;
   logic signed [DELTA_WIDTH-1:0] s1_delta_ff, s1_delta_in;
   logic [TIME_WIDTH-1:0]      s1_now_ff, s1_now_in;

   // detector state
   logic signed [ACC_WIDTH-1:0] sum_x_ff, sum_x_in;
   logic signed [ACC_WIDTH-1:0] sum_y_ff, sum_y_in;
   logic [ACC_WIDTH-1:0]       total_ff, total_in;
   logic [TIME_WIDTH-1:0]      begin_ms_ff, begin_ms_in;
   logic [TIME_WIDTH-1:0]      last_fast_ff, last_fast_in;
   logic                       active_ff, active_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_fast_ff, rsp_fast_in;
   logic                       rsp_on_ff, rsp_on_in;
   logic                       rsp_off_ff, rsp_off_in;

   logic                       s1_advance;
   logic                       req_accept;

   logic signed [ACC_WIDTH:0]  add_x, add_y;
   logic signed [ACC_WIDTH:0]  delta_ext;
   logic signed [ACC_WIDTH-1:0] sat_x, sat_y;
   logic [ACC_WIDTH-1:0]       mag_x, mag_y;
   logic [ACC_WIDTH:0]         dist_sum, total_sum;
   logic [ACC_WIDTH-1:0]       frame_dist, total_new;
   logic [TIME_WIDTH-1:0]      since_begin, since_fast;
   logic                       window_done, cooled, is_fast;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_WIDTH-3){1'b0}}, rsp_off_ff, rsp_on_ff, rsp_fast_ff};

   // saturating frame sums
   assign delta_ext = (ACC_WIDTH+1)'(s1_delta_ff);
   assign add_x = {sum_x_ff[ACC_WIDTH-1], sum_x_ff} + delta_ext;
   assign add_y = {sum_y_ff[ACC_WIDTH-1], sum_y_ff} + delta_ext;

   always_comb begin
      if (add_x[ACC_WIDTH] != add_x[ACC_WIDTH-1]) begin
         sat_x = {add_x[ACC_WIDTH], {(ACC_WIDTH-1){~add_x[ACC_WIDTH]}}};
      end else begin
         sat_x = add_x[ACC_WIDTH-1:0];
      end
      if (add_y[ACC_WIDTH] != add_y[ACC_WIDTH-1]) begin
         sat_y = {add_y[ACC_WIDTH], {(ACC_WIDTH-1){~add_y[ACC_WIDTH]}}};
      end else begin
         sat_y = add_y[ACC_WIDTH-1:0];
      end
   end

   // manhattan distance and window total
   assign mag_x      = sum_x_ff[ACC_WIDTH-1] ? (~sum_x_ff + ACC_WIDTH'(1)) : sum_x_ff;
   assign mag_y      = sum_y_ff[ACC_WIDTH-1] ? (~sum_y_ff + ACC_WIDTH'(1)) : sum_y_ff;
   assign dist_sum   = {1'b0, mag_x} + {1'b0, mag_y};
   assign frame_dist = dist_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : dist_sum[ACC_WIDTH-1:0];
   assign total_sum  = {1'b0, total_ff} + {1'b0, frame_dist};
   assign total_new  = total_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : total_sum[ACC_WIDTH-1:0];

   assign since_begin = s1_now_ff - begin_ms_ff;
   assign since_fast  = s1_now_ff - last_fast_ff;
   assign window_done = since_begin >= TIME_WIDTH'(window_len_ff);
   assign cooled      = since_fast > TIME_WIDTH'(cooldown_ff);
   assign is_fast     = CMP_WIDTH'(total_new) >= CMP_WIDTH'(threshold_ff);

   always_comb begin
      threshold_in  = threshold_ff;
      window_len_in = window_len_ff;
      cooldown_in   = cooldown_ff;
      if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_MOTION_THRESHOLD: threshold_in  = csr_data[THRESHOLD_WIDTH-1:0];
            REG_WINDOW_LENGTH:    window_len_in = csr_data[MS_CFG_WIDTH-1:0];
            REG_COOLDOWN:         cooldown_in   = csr_data[MS_CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_delta_in = s1_delta_ff;
      s1_now_in   = s1_now_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_op_in    = op_type'(req_tuser);
         s1_delta_in = req_tdata[DELTA_WIDTH-1:0];
         s1_now_in   = req_tdata[DELTA_WIDTH +: TIME_WIDTH];
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      total_in     = total_ff;
      begin_ms_in  = begin_ms_ff;
      last_fast_in = last_fast_ff;
      active_in    = active_ff;
      if (s1_advance) begin
         case (s1_op_ff)
            OP_DX: sum_x_in = sat_x;
            OP_DY: sum_y_in = sat_y;
            OP_SYNC: begin
               sum_x_in = '0;
               sum_y_in = '0;
               if (frame_dist != '0) begin
                  total_in = total_new;
                  if (window_done) begin
                     if (is_fast) begin
                        last_fast_in = s1_now_ff;
                        active_in    = 1'b1;
                     end else if (active_ff && cooled) begin
                        active_in = 1'b0;
                     end
                     total_in    = '0;
                     begin_ms_in = s1_now_ff;
                  end
               end
            end
            OP_IDLE: begin
               if (active_ff && cooled) begin
                  active_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_fast_in  = rsp_fast_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_off_in   = rsp_off_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_fast_in  = active_in;
         rsp_on_in    = !active_ff && active_in;
         rsp_off_in   = active_ff && !active_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET[THRESHOLD_WIDTH-1:0];
         window_len_ff <= WINDOW_RESET;
         cooldown_ff   <= COOLDOWN_RESET;
         s1_valid_ff   <= 1'b0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         total_ff      <= '0;
         begin_ms_ff   <= '0;
         last_fast_ff  <= '0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         threshold_ff  <= threshold_in;
         window_len_ff <= window_len_in;
         cooldown_ff   <= cooldown_in;
         s1_valid_ff   <= s1_valid_in;
         sum_x_ff      <= sum_x_in;
         sum_y_ff      <= sum_y_in;
         total_ff      <= total_in;
         begin_ms_ff   <= begin_ms_in;
         last_fast_ff  <= last_fast_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      s1_delta_ff <= s1_delta_in;
      s1_now_ff   <= s1_now_in;
      rsp_fast_ff <= rsp_fast_in;
      rsp_on_ff   <= rsp_on_in;
      rsp_off_ff  <= rsp_off_in;
   end

   a_edges_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_on_ff && rsp_off_ff))
      else $error("result marks both on and off edges");

   a_on_means_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_on_ff |-> rsp_fast_ff)
      else $error("on edge reported with flag clear");

   a_off_means_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_off_ff |-> !rsp_fast_ff)
      else $error("off edge reported with flag set");

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff && (rsp_fast_ff == active_ff))
      else $error("result register does not match detector state");

endmodule

// ===== test/fast_motion_detector_test.sv =====
`timescale 1ns / 100ps

module fast_motion_detector_test;
   import fmd_pkg::*;

   localparam int     ACC_W     = 24;
   localparam longint SUM_HI    = (longint'(1) << (ACC_W - 1)) - 1;
   localparam longint SUM_LO    = -SUM_HI - 1;
   localparam longint TOTAL_MAX = (longint'(1) << ACC_W) - 1;
   localparam int     LIMIT     = 400000;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NONE = 2'd3;

   typedef struct packed {
      logic active;
      logic rise;
      logic fall;
   } flags_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;   // delta[15:0], now_ms[47:16]
   logic [1:0]                 req_tuser;   // opcode[1:0]
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;   // fast_active, became_active,
                                            // became_inactive, zero pad
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   // predicted detector state and settings
   longint      acc_x        = 0;
   longint      acc_y        = 0;
   longint      dist_total   = 0;
   logic [31:0] win_begin    = '0;
   logic [31:0] fast_stamp   = '0;
   logic        flag_on      = 1'b0;
   logic [23:0] threshold    = THRESHOLD_RESET;
   logic [15:0] window_len   = WINDOW_RESET;
   logic [15:0] cooldown     = COOLDOWN_RESET;

   flags_type   expected_flags[$];
   logic [31:0] stamp;
   int          events_sent = 0;
   int          mismatches = 0;
   int          cycles = 0;
   logic        gaps_on;
   logic        sink_eager;

   fast_motion_detector #(.ACC_WIDTH(ACC_W)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint clamp_signed(input longint v);
      if (v > SUM_HI) return SUM_HI;
      if (v < SUM_LO) return SUM_LO;
      return v;
   endfunction

   function automatic longint clamp_unsigned(input longint v);
      return (v > TOTAL_MAX) ? TOTAL_MAX : v;
   endfunction

   function automatic flags_type predict_flags(input op_type op, input logic [15:0] delta,
                                               input logic [31:0] now);
      longint      frame_dist;
      logic [31:0] since_start;
      logic [31:0] since_fast;
      logic        was;
      flags_type   f;
      was = flag_on;
      since_start = now - win_begin;
      since_fast = now - fast_stamp;
      case (op)
         OP_DX: acc_x = clamp_signed(acc_x + longint'($signed(delta)));
         OP_DY: acc_y = clamp_signed(acc_y + longint'($signed(delta)));
         OP_SYNC: begin
            frame_dist = clamp_unsigned((acc_x < 0 ? -acc_x : acc_x) +
                                        (acc_y < 0 ? -acc_y : acc_y));
            acc_x = 0;
            acc_y = 0;
            if (frame_dist != 0) begin
               dist_total = clamp_unsigned(dist_total + frame_dist);
               if (since_start >= window_len) begin
                  if (dist_total >= threshold) begin
                     fast_stamp = now;
                     flag_on = 1'b1;
                  end else if (flag_on && since_fast > cooldown) begin
                     flag_on = 1'b0;
                  end
                  dist_total = 0;
                  win_begin = now;
               end
            end
         end
         default: begin
            if (flag_on && since_fast > cooldown) flag_on = 1'b0;
         end
      endcase
      f.active = flag_on;
      f.rise = !was && flag_on;
      f.fall = was && !flag_on;
      return f;
   endfunction

   task automatic send_event(input op_type op, input logic [15:0] delta,
                             input logic [31:0] now);
      int gap;
      gap = gaps_on ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18)) : 0;
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {now, delta};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_flags.push_back(predict_flags(op, delta, now));
      events_sent++;
   endtask

   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (expected_flags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MOTION_THRESHOLD: threshold = value;
         REG_WINDOW_LENGTH:    window_len = value[15:0];
         REG_COOLDOWN:         cooldown = value[15:0];
         default: ;
      endcase
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      send_event(OP_DX, 16'h7FFF, 32'd0);
      send_event(OP_DY, 16'h8000, 32'd1);
      send_event(OP_SYNC, 16'hFFFF, 32'd10);
      send_event(OP_IDLE, 16'h5A5A, 32'd20);
      send_event(OP_SYNC, 16'h0000, 32'd30);
      send_event(OP_DX, 16'd5, 32'd50);
      send_event(OP_SYNC, 16'd0, 32'd50);
      send_event(OP_IDLE, 16'd0, 32'd850);
      send_event(OP_IDLE, 16'hA5A5, 32'd851);
      send_event(OP_DX, 16'd1, 32'd900);
      send_event(OP_SYNC, 16'd0, 32'd900);
      send_event(OP_DY, 16'd300, 32'd905);
      send_event(OP_SYNC, 16'd0, 32'd920);
      send_event(OP_DX, 16'd1, 32'd930);
      send_event(OP_SYNC, 16'd0, 32'd940);
      // time stepping backwards
      send_event(OP_DX, 16'd1, 32'd935);
      send_event(OP_SYNC, 16'd0, 32'd930);
      // cooldown across the time wrap
      send_event(OP_DX, 16'd400, 32'd936);
      send_event(OP_SYNC, 16'd0, 32'hFFFF_FFF0);
      send_event(OP_IDLE, 16'd0, 32'h0000_0310);
      send_event(OP_IDLE, 16'd0, 32'h0000_0311);
      drain();
   endtask

   task automatic test_zero_window();
      write_reg(REG_WINDOW_LENGTH, 24'hFF_0000);
      write_reg(REG_MOTION_THRESHOLD, 24'd0);
      write_reg(REG_COOLDOWN, 24'hAB_0000);
      write_reg(REG_NONE, 24'hFF_FFFF);
      send_event(OP_SYNC, 16'd0, 32'd2000);
      send_event(OP_DX, 16'hFFFF, 32'd2000);
      send_event(OP_SYNC, 16'd0, 32'd2000);
      send_event(OP_IDLE, 16'd0, 32'd2000);
      send_event(OP_IDLE, 16'd0, 32'd2001);
      send_event(OP_DY, 16'd1, 32'd2001);
      send_event(OP_SYNC, 16'd0, 32'd2001);
      drain();
   endtask

   task automatic test_saturation();
      write_reg(REG_MOTION_THRESHOLD, 24'hFF_FFFF);
      write_reg(REG_WINDOW_LENGTH, 24'h00_FFFF);
      write_reg(REG_COOLDOWN, 24'h12_FFFF);
      gaps_on = 1'b0;
      repeat (257) send_event(OP_DX, 16'h8000, 32'd5000);
      repeat (257) send_event(OP_DY, 16'h8000, 32'd5000);
      send_event(OP_SYNC, 16'd0, 32'd5000);
      repeat (257) send_event(OP_DX, 16'h7FFF, 32'd5001);
      send_event(OP_SYNC, 16'd0, 32'd5001);
      gaps_on = 1'b1;
      send_event(OP_DY, 16'd1, 32'd67536);
      send_event(OP_SYNC, 16'd0, 32'd67536);
      send_event(OP_IDLE, 16'd0, 32'd133071);
      send_event(OP_IDLE, 16'd0, 32'd133072);
      drain();
      stamp = 32'd133072;
   endtask

   task automatic test_random_frames(input int count);
      int stop_at;
      int kind;
      int len;
      stop_at = events_sent + count;
      while (events_sent < stop_at) begin
         kind = $urandom_range(0, 19);
         if (kind < 15) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
               stamp += $urandom_range(0, 3);
               send_event($urandom_range(0, 1) ? OP_DX : OP_DY,
                          ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 400) - 200),
                          stamp);
            end
            stamp += $urandom_range(0, 40);
            send_event(OP_SYNC, 16'($urandom), stamp);
         end else if (kind < 17) begin
            stamp += $urandom_range(0, 300);
            send_event(OP_IDLE, 16'($urandom), stamp);
         end else if (kind == 17) begin
            stamp = $urandom;
            send_event(op_type'($urandom_range(0, 3)), 16'($urandom), stamp);
         end else if (kind == 18) begin
            send_event(op_type'($urandom_range(0, 3)), 16'($urandom), stamp);
         end else begin
            drain();
         end
      end
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 4; p++) begin
         drain();
         write_reg(REG_MOTION_THRESHOLD, 24'($urandom_range(0, 3000)));
         write_reg(REG_WINDOW_LENGTH, {8'($urandom), 16'($urandom_range(0, 100))});
         write_reg(REG_COOLDOWN, {8'($urandom), 16'($urandom_range(0, 400))});
         gaps_on = (p == 0 || p == 2);
         sink_eager = (p == 1 || p == 2);
         test_random_frames(25);
      end
   endtask

   // result side back-pressure
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = sink_eager ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18));
         if (stall > 0) begin
            @(negedge clock) rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid === 1'b1 && rsp_tready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_results
      flags_type want;
      flags_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.active = rsp_tdata[0];
         got.rise = rsp_tdata[1];
         got.fall = rsp_tdata[2];
         if (expected_flags.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: rsp_tdata %b", rsp_tdata);
         end else begin
            want = expected_flags.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: active %b/%b rise %b/%b fall %b/%b (expected/actual)",
                           want.active, got.active, want.rise, got.rise,
                           want.fall, got.fall);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = OP_DX;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = REG_MOTION_THRESHOLD;
      csr_data = '0;
      gaps_on = 1'b1;
      sink_eager = 1'b0;
      stamp = '0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_directed();
      test_zero_window();
      test_saturation();
      test_random_settings();
      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_flags.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
